/* rtl/pfd_pkg.sv */
// Shared types and constants for the Playfair digraph decrypter.
// Used by every module under rtl; depends on nothing.
package pfd_pkg;

  localparam int unsigned SIDE       = 5;
  localparam int unsigned CELLS      = SIDE * SIDE;
  localparam int unsigned LETTER_W   = 5;
  localparam int unsigned RC_W       = 3;
  localparam int unsigned CELL_IDX_W = 5;
  localparam int unsigned CFG_W      = 50;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;

  localparam logic [CFG_IDX_W-1:0] REG_SQUARE_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE_C = 2'd2;

  // Row-major key square, cell k in bits 5k+4..5k.
  typedef logic [CELLS-1:0][LETTER_W-1:0] square_t;

  typedef struct packed {
    logic [LETTER_W-1:0] first_cipher_letter;
    logic [LETTER_W-1:0] second_cipher_letter;
  } pfd_in_t;

  typedef struct packed {
    logic [LETTER_W-1:0] first_plain_letter;
    logic [LETTER_W-1:0] second_plain_letter;
    logic                letter_missing;
  } pfd_out_t;

  // Classified digraph: square positions of both letters.
  typedef struct packed {
    logic [RC_W-1:0] row1;
    logic [RC_W-1:0] col1;
    logic [RC_W-1:0] row2;
    logic [RC_W-1:0] col2;
    logic            missing;
  } pfd_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } pfd_qstat_t;

endpackage

/* rtl/pfd_front.sv */
// Front end: normalises J to I and locates both letters in the key square.
// Depends on pfd_pkg.
module pfd_front (
  input  pfd_pkg::square_t    square,
  input  pfd_pkg::pfd_in_t    cipher,
  output pfd_pkg::pfd_entry_t entry
);
  import pfd_pkg::*;

  // Returns {found, row, col} of the lowest-index cell holding the letter.
  function automatic logic [2*RC_W:0] locate(square_t sq, logic [LETTER_W-1:0] letter);
    logic [LETTER_W-1:0] key;
    logic [CELLS-1:0]    hit;
    logic [SIDE-1:0]     row_hit;
    logic [SIDE-1:0]     sel_row;
    logic [RC_W-1:0]     row;
    logic [RC_W-1:0]     col;
    key = (letter == LETTER_J) ? LETTER_I : letter;
    for (int k = 0; k < CELLS; k++) begin
      hit[k] = (sq[k] == key);
    end
    for (int r = 0; r < SIDE; r++) begin
      row_hit[r] = |hit[r*SIDE +: SIDE];
    end
    row = '0;
    for (int r = SIDE - 1; r >= 0; r--) begin
      if (row_hit[r]) begin
        row = RC_W'(r);
      end
    end
    sel_row = hit[row*SIDE +: SIDE];
    col = '0;
    for (int c = SIDE - 1; c >= 0; c--) begin
      if (sel_row[c]) begin
        col = RC_W'(c);
      end
    end
    return {|row_hit, row, col};
  endfunction

  logic [2*RC_W:0] loc1;
  logic [2*RC_W:0] loc2;

  assign loc1 = locate(square, cipher.first_cipher_letter);
  assign loc2 = locate(square, cipher.second_cipher_letter);

  assign entry.row1    = loc1[2*RC_W-1:RC_W];
  assign entry.col1    = loc1[RC_W-1:0];
  assign entry.row2    = loc2[2*RC_W-1:RC_W];
  assign entry.col2    = loc2[RC_W-1:0];
  assign entry.missing = ~(loc1[2*RC_W] & loc2[2*RC_W]);

endmodule

/* rtl/pfd_queue.sv */
// Short FIFO of classified digraphs between front and back end.
// Depends on pfd_pkg.
module pfd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pfd_pkg::pfd_entry_t push_entry,
  input  logic                pop,
  output pfd_pkg::pfd_entry_t head,
  output pfd_pkg::pfd_qstat_t stat
);
  import pfd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pfd_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/pfd_back.sv */
// Back end: applies the row, column or rectangle rule and reads the plaintext
// cells from the key square into the result register. Depends on pfd_pkg.
module pfd_back (
  input  logic                clk,
  input  logic                rst,
  input  pfd_pkg::square_t    square,
  input  pfd_pkg::pfd_entry_t entry,
  input  logic                entry_valid,
  output pfd_pkg::pfd_out_t   plain,
  output logic                done
);
  import pfd_pkg::*;

  function automatic logic [RC_W-1:0] step_back(logic [RC_W-1:0] x);
    return (x == '0) ? RC_W'(SIDE - 1) : x - 1'b1;
  endfunction

  function automatic logic [CELL_IDX_W-1:0] cell_idx(logic [RC_W-1:0] r,
                                                    logic [RC_W-1:0] c);
    return CELL_IDX_W'({2'b00, r} * CELL_IDX_W'(SIDE) + {2'b00, c});
  endfunction

  logic [RC_W-1:0] o_row1;
  logic [RC_W-1:0] o_col1;
  logic [RC_W-1:0] o_row2;
  logic [RC_W-1:0] o_col2;
  pfd_out_t        plain_next;

  always_comb begin
    priority if (entry.row1 == entry.row2) begin
      o_row1 = entry.row1;
      o_col1 = step_back(entry.col1);
      o_row2 = entry.row2;
      o_col2 = step_back(entry.col2);
    end else if (entry.col1 == entry.col2) begin
      o_row1 = step_back(entry.row1);
      o_col1 = entry.col1;
      o_row2 = step_back(entry.row2);
      o_col2 = entry.col2;
    end else begin
      // rectangle: swap columns
      o_row1 = entry.row1;
      o_col1 = entry.col2;
      o_row2 = entry.row2;
      o_col2 = entry.col1;
    end
  end

  always_comb begin
    if (entry.missing) begin
      plain_next.first_plain_letter  = '0;
      plain_next.second_plain_letter = '0;
      plain_next.letter_missing      = 1'b1;
    end else begin
      plain_next.first_plain_letter  = square[cell_idx(o_row1, o_col1)];
      plain_next.second_plain_letter = square[cell_idx(o_row2, o_col2)];
      plain_next.letter_missing      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_valid) begin
      plain <= plain_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= entry_valid;
    end
  end

endmodule

/* rtl/playfair_digraph_decrypt_top.sv */
// Top level of the Playfair digraph decrypter: key square registers, front
// end, queue and back end. Depends on pfd_pkg, pfd_front, pfd_queue, pfd_back.
//
//   channel   ports                          transfer
//   input     start, busy, cipher            start && !busy at a rising edge
//   result    done, plain                    done high for one cycle
//   config    cfg_write, cfg_index, cfg_data cfg_write at a rising edge
//
// One digraph is accepted per cycle while busy is low. The accepting edge
// writes the queue; the back end's result register and done then load from
// the queue head, and the result is taken while done is high. The back end
// drains one entry every cycle the queue is not empty, so the queue holds at
// most one entry and busy stays low unless QUEUE_DEPTH is 1. Reset clears the
// key square, queue and strobe. The receiver cannot stall; done is never held.
module playfair_digraph_decrypt_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  pfd_pkg::pfd_in_t                  cipher,
  output logic                              done,
  output pfd_pkg::pfd_out_t                 plain,
  input  logic                              cfg_write,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfd_pkg::CFG_W-1:0]         cfg_data
);
  import pfd_pkg::*;

  logic [49:0] square_a;
  logic [49:0] square_b;
  logic [24:0] square_c;
  square_t     square;
  pfd_entry_t  front_entry;
  pfd_entry_t  head;
  pfd_qstat_t  q_stat;
  logic        accept;

  assign square = {square_c, square_b, square_a};
  assign busy   = q_stat.full;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      square_a <= '0;
      square_b <= '0;
      square_c <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SQUARE_A: square_a <= cfg_data[49:0];
        REG_SQUARE_B: square_b <= cfg_data[49:0];
        REG_SQUARE_C: square_c <= cfg_data[24:0];
        default:      ; // drop writes to unused indices
      endcase
    end
  end

  pfd_front u_front (
    .square (square),
    .cipher (cipher),
    .entry  (front_entry)
  );

  pfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (front_entry),
    .pop        (!q_stat.empty),
    .head       (head),
    .stat       (q_stat)
  );

  pfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .square      (square),
    .entry       (head),
    .entry_valid (!q_stat.empty),
    .plain       (plain),
    .done        (done)
  );

  a_accept_queued: assert property (@(posedge clk) disable iff (rst)
    accept |=> !q_stat.empty)
    else $error("accepted transaction did not reach the queue");

  a_drain_to_result: assert property (@(posedge clk) disable iff (rst)
    !q_stat.empty |=> done)
    else $error("queued entry did not produce a result");

  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    (done && plain.letter_missing) |->
      (plain.first_plain_letter == '0 && plain.second_plain_letter == '0))
    else $error("missing-letter result carries non-zero letters");

endmodule
